FILE: rtl/core/binary_image_neighbour_mask_store_assert.svh
// Assertion macros for the checker file
`ifndef BINARY_IMAGE_NEIGHBOUR_MASK_STORE_ASSERT_SVH
`define BINARY_IMAGE_NEIGHBOUR_MASK_STORE_ASSERT_SVH

// implication checked outside reset
`define BNMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define BNMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked at every edge, reset included
`define BNMS_ASSERT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/bnms_pkg.sv
// Shared types and constants for the binary image neighbour mask store
package bnms_pkg;

    localparam int IMAGE_ROWS_DEF = 256;
    localparam int IMAGE_COLS_DEF = 256;
    localparam int CMD_DEPTH      = 2;

    // register indexes
    localparam int REG_TRACKING = 0;
    localparam int REG_COUNT    = 1;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_FIND  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] row;
        logic [7:0] col;
    } t_in_item;

    typedef struct packed {
        logic       pixel_value;
        logic [7:0] neighbour_mask;
        logic       found;
        logic [7:0] found_row;
        logic [7:0] found_col;
    } t_out_item;

    typedef struct packed {
        t_action    action;
        logic [7:0] row;
        logic [7:0] col;
        logic       in_image;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

FILE: rtl/core/binary_image_neighbour_mask_store.sv
// Top level of the binary image store with per-pixel neighbour masks
//
// channel  | direction | handshake                      | payload
// item     | in        | i_push / o_full                | i_item (action, row, col)
// result   | out       | o_empty / i_pop                | o_result (pixel, mask, find)
// config   | in        | psel penable pwrite pready     | paddr, pwdata, prdata
//
// One item at a time in the back end. A read, or a set/clear that changes nothing, passes
// S_PRD, S_PCHK, S_MRD, S_MOUT. A set/clear that flips the pixel with tracking on adds
// S_NRD, S_NWR per in-image neighbour and S_NRD per one outside (mask read-modify-write
// on a single-port memory). Find-first: S_SRD, S_SCHK per image word scanned, S_SBIT on a
// hit. After reset a clearing pass writes zero to both memories, over max(pixel words,
// mask words) addresses (8192 at 256x256), with o_full held high. The command queue
// keeps taking items while a result waits to be popped.
module binary_image_neighbour_mask_store #(
    parameter int IMAGE_ROWS = bnms_pkg::IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = bnms_pkg::IMAGE_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  bnms_pkg::t_in_item  i_item,
    output logic                o_empty,
    input  logic                i_pop,
    output bnms_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    bnms_pkg::t_cmd      front_cmd;
    bnms_pkg::t_cmd      q_cmd;
    bnms_pkg::t_q_status q_status;
    logic                cmd_pop;
    logic                out_valid;
    logic                clearing;
    logic                r_tracking;
    logic                reg_sel;

    assign reg_sel = 32'(paddr[2]) == bnms_pkg::REG_TRACKING;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, r_tracking} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_tracking <= pwdata[0];
        end
    end

    assign o_full  = q_status.full || clearing;
    assign o_empty = !out_valid;

    bnms_front #(
        .IMAGE_ROWS(IMAGE_ROWS),
        .IMAGE_COLS(IMAGE_COLS)
    ) u_front (
        .i_item(i_item),
        .o_cmd (front_cmd)
    );

    bnms_cmd_fifo #(
        .DEPTH(bnms_pkg::CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (q_cmd),
        .o_status(q_status)
    );

    bnms_back #(
        .IMAGE_ROWS(IMAGE_ROWS),
        .IMAGE_COLS(IMAGE_COLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tracking (r_tracking),
        .i_cmd_valid(q_status.valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (cmd_pop),
        .i_pop      (i_pop),
        .o_out_valid(out_valid),
        .o_result   (o_result),
        .o_clearing (clearing)
    );

endmodule

FILE: rtl/core/bnms_front.sv
// Front end: decodes an incoming item and checks its address against the image
module bnms_front #(
    parameter int IMAGE_ROWS = bnms_pkg::IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = bnms_pkg::IMAGE_COLS_DEF
) (
    input  bnms_pkg::t_in_item i_item,
    output bnms_pkg::t_cmd     o_cmd
);

    logic row_ok;
    logic col_ok;

    assign row_ok = 32'(i_item.row) < 32'(IMAGE_ROWS);
    assign col_ok = 32'(i_item.col) < 32'(IMAGE_COLS);

    always_comb begin
        o_cmd.action   = bnms_pkg::t_action'(i_item.action);
        o_cmd.row      = i_item.row;
        o_cmd.col      = i_item.col;
        o_cmd.in_image = row_ok && col_ok;
    end

endmodule

FILE: rtl/core/bnms_cmd_fifo.sv
// Short command queue between front end and back end
module bnms_cmd_fifo #(
    parameter int DEPTH = bnms_pkg::CMD_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bnms_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output bnms_pkg::t_cmd      o_cmd,
    output bnms_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bnms_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic do_push;
    logic do_pop;

    assign o_status.full  = r_cnt == CNT_W'(DEPTH);
    assign o_status.valid = r_cnt != '0;
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/bnms_back.sv
// Back end: image and mask memories, update sequencer, scan and result register
module bnms_back #(
    parameter int IMAGE_ROWS = bnms_pkg::IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = bnms_pkg::IMAGE_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tracking,
    input  logic                i_cmd_valid,
    input  bnms_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_out_valid,
    output bnms_pkg::t_out_item o_result,
    output logic                o_clearing
);

    localparam int PIX_WPR   = (IMAGE_COLS + 63) / 64;
    localparam int MSK_WPR   = (IMAGE_COLS + 7) / 8;
    localparam int PIX_WORDS = IMAGE_ROWS * PIX_WPR;
    localparam int MSK_WORDS = IMAGE_ROWS * MSK_WPR;
    localparam int PA_W      = $clog2(PIX_WORDS);
    localparam int MA_W      = $clog2(MSK_WORDS);
    localparam int CLR_N     = (PIX_WORDS > MSK_WORDS) ? PIX_WORDS : MSK_WORDS;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int SR_W      = $clog2(IMAGE_ROWS);
    localparam int SW_W      = (PIX_WPR > 1) ? $clog2(PIX_WPR) : 1;
    localparam logic signed [13:0] ROWS_S = 14'(IMAGE_ROWS);
    localparam logic signed [13:0] COLS_S = 14'(IMAGE_COLS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRD, S_PCHK, S_NRD, S_NWR,
        S_MRD, S_MOUT, S_SRD, S_SCHK, S_SBIT
    } t_state;

    logic [63:0] pix_mem [PIX_WORDS];
    logic [63:0] msk_mem [MSK_WORDS];

    t_state              r_state;
    logic [CLR_W-1:0]    r_clr;
    bnms_pkg::t_cmd      r_cmd;
    logic [PA_W-1:0]     r_paddr;
    logic [MA_W-1:0]     r_maddr;
    logic [63:0]         r_pdata;
    logic [63:0]         r_mdata;
    logic                r_pix;
    logic [2:0]          r_n;
    logic [PA_W-1:0]     r_saddr;
    logic [SR_W-1:0]     r_srow;
    logic [SW_W-1:0]     r_sword;
    logic [7:0]          r_sbyte;
    logic [2:0]          r_sbidx;
    logic                r_out_valid;
    bnms_pkg::t_out_item r_out;

    logic                p_re, p_we, m_re, m_we;
    logic [PA_W-1:0]     p_ra, p_wa;
    logic [MA_W-1:0]     m_ra, m_wa;
    logic [63:0]         p_wd, m_wd;
    logic signed [13:0]  dr, dc, nb_r, nb_c;
    logic                nb_in;
    logic [MA_W-1:0]     nb_addr;
    logic [5:0]          nb_bit;
    logic                cur_bit;
    logic                want;
    logic                change;
    logic [2:0]          byte_idx;
    logic [2:0]          bit_idx;

    // neighbour n, direction code equals n
    always_comb begin
        unique case (r_n)
            3'd0: begin dr = 14'sd0;  dc = 14'sd1;  end
            3'd1: begin dr = -14'sd1; dc = 14'sd1;  end
            3'd2: begin dr = -14'sd1; dc = 14'sd0;  end
            3'd3: begin dr = -14'sd1; dc = -14'sd1; end
            3'd4: begin dr = 14'sd0;  dc = -14'sd1; end
            3'd5: begin dr = 14'sd1;  dc = -14'sd1; end
            3'd6: begin dr = 14'sd1;  dc = 14'sd0;  end
            default: begin dr = 14'sd1; dc = 14'sd1; end
        endcase
        nb_r    = $signed({6'b0, r_cmd.row}) + dr;
        nb_c    = $signed({6'b0, r_cmd.col}) + dc;
        nb_in   = nb_r >= 0 && nb_r < ROWS_S && nb_c >= 0 && nb_c < COLS_S;
        nb_addr = MA_W'(32'(nb_r[12:0]) * MSK_WPR + 32'(nb_c[12:3]));
        nb_bit  = {nb_c[2:0], r_n};
    end

    assign cur_bit = r_pdata[r_cmd.col[5:0]];
    assign want    = r_cmd.action == bnms_pkg::ACT_SET;
    assign change  = (r_cmd.action == bnms_pkg::ACT_SET || r_cmd.action == bnms_pkg::ACT_CLEAR)
                     && cur_bit != want;

    always_comb begin
        byte_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (|r_pdata[i*8 +: 8]) begin
                byte_idx = 3'(i);
            end
        end
        bit_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (r_sbyte[i]) begin
                bit_idx = 3'(i);
            end
        end
    end

    always_comb begin
        p_re = 1'b0; p_ra = r_paddr;
        p_we = 1'b0; p_wa = r_paddr; p_wd = r_pdata ^ (64'd1 << r_cmd.col[5:0]);
        m_re = 1'b0; m_ra = r_maddr;
        m_we = 1'b0; m_wa = nb_addr; m_wd = r_mdata ^ (64'd1 << nb_bit);
        unique case (r_state)
            S_CLEAR: begin
                p_we = 32'(r_clr) < PIX_WORDS;
                p_wa = PA_W'(r_clr);
                p_wd = '0;
                m_we = 32'(r_clr) < MSK_WORDS;
                m_wa = MA_W'(r_clr);
                m_wd = '0;
            end
            S_PRD:  p_re = 1'b1;
            S_PCHK: p_we = change;
            S_NRD: begin
                m_re = nb_in;
                m_ra = nb_addr;
            end
            S_NWR:  m_we = 1'b1;
            S_MRD:  m_re = 1'b1;
            S_SRD: begin
                p_re = 1'b1;
                p_ra = r_saddr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pix_mem[p_wa] <= p_wd;
        end
        if (p_re) begin
            r_pdata <= pix_mem[p_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            msk_mem[m_wa] <= m_wd;
        end
        if (m_re) begin
            r_mdata <= msk_mem[m_ra];
        end
    end

    assign o_cmd_pop   = r_state == S_IDLE && i_cmd_valid && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_clearing  = r_state == S_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (32'(r_clr) == CLR_N - 1) begin
                        r_state <= S_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd   <= i_cmd;
                        r_paddr <= PA_W'(32'(i_cmd.row) * PIX_WPR + 32'(i_cmd.col[7:6]));
                        r_maddr <= MA_W'(32'(i_cmd.row) * MSK_WPR + 32'(i_cmd.col[7:3]));
                        r_saddr <= '0;
                        r_srow  <= '0;
                        r_sword <= '0;
                        if (i_cmd.action == bnms_pkg::ACT_FIND) begin
                            r_state <= S_SRD;
                        end else if (!i_cmd.in_image) begin
                            r_out       <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_PRD;
                        end
                    end
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    r_pix <= change ? want : cur_bit;
                    r_n   <= '0;
                    r_state <= (change && i_tracking) ? S_NRD : S_MRD;
                end
                S_NRD: begin
                    if (nb_in) begin
                        r_state <= S_NWR;
                    end else if (r_n == 3'd7) begin
                        r_state <= S_MRD;
                    end else begin
                        r_n <= r_n + 3'd1;
                    end
                end
                S_NWR: begin
                    if (r_n == 3'd7) begin
                        r_state <= S_MRD;
                    end else begin
                        r_n     <= r_n + 3'd1;
                        r_state <= S_NRD;
                    end
                end
                S_MRD: r_state <= S_MOUT;
                S_MOUT: begin
                    r_out                <= '0;
                    r_out.pixel_value    <= r_pix;
                    r_out.neighbour_mask <= r_mdata[{r_cmd.col[2:0], 3'b000} +: 8];
                    r_out_valid          <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (r_pdata != '0) begin
                        r_sbyte <= r_pdata[{byte_idx, 3'b000} +: 8];
                        r_sbidx <= byte_idx;
                        r_state <= S_SBIT;
                    end else if (32'(r_saddr) == PIX_WORDS - 1) begin
                        r_out       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_saddr <= r_saddr + 1'b1;
                        if (32'(r_sword) == PIX_WPR - 1) begin
                            r_sword <= '0;
                            r_srow  <= r_srow + 1'b1;
                        end else begin
                            r_sword <= r_sword + 1'b1;
                        end
                        r_state <= S_SRD;
                    end
                end
                S_SBIT: begin
                    r_out           <= '0;
                    r_out.found     <= 1'b1;
                    r_out.found_row <= 8'(r_srow);
                    r_out.found_col <= 8'(32'(r_sword) * 64 + 32'({r_sbidx, bit_idx}));
                    r_out_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/bnms_checker.sv
// Port-level checker for the binary image store, bound to the top level
`include "binary_image_neighbour_mask_store_assert.svh"

module bnms_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_full,
    input logic                o_empty,
    input logic                i_pop,
    input bnms_pkg::t_out_item o_result
);

    `BNMS_ASSERT_ALL(a_full_after_reset, i_clk, $rose(i_rst_n), o_full, "not full after reset")
    `BNMS_ASSERT_ALL(a_empty_after_reset, i_clk, $rose(i_rst_n), o_empty, "result after reset")
    `BNMS_ASSERT_NXT(a_result_held, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_result), "waiting result changed")
    `BNMS_ASSERT_IMP(a_find_fields, i_clk, i_rst_n, !o_empty && o_result.found, !o_result.pixel_value && o_result.neighbour_mask == 8'd0, "find result carries pixel data")

endmodule

bind binary_image_neighbour_mask_store bnms_checker u_bnms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_result(o_result)
);

FILE: test/tb_binary_image_neighbour_mask_store.sv
// Self-checking testbench for the binary image store with neighbour masks
`timescale 1ns / 1ps

module tb_binary_image_neighbour_mask_store;

    localparam int N_ROWS = 256;
    localparam int N_COLS = 256;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_push = 1'b0;
    logic                o_full;
    bnms_pkg::t_in_item  i_item = '0;
    logic                o_empty;
    logic                i_pop = 1'b0;
    bnms_pkg::t_out_item o_result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    binary_image_neighbour_mask_store u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow image, per-pixel masks and tracking switch
    logic       img [N_ROWS][N_COLS];
    logic [7:0] nmask [N_ROWS][N_COLS];
    logic       track_on;

    bnms_pkg::t_out_item pending_results[$];
    int         errors = 0;
    int         n_pushed = 0;
    int         n_popped = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic void flip_dir(int r, int c, int dir);
        if (r >= 0 && r < N_ROWS && c >= 0 && c < N_COLS)
            nmask[r][c][dir] = ~nmask[r][c][dir];
    endfunction

    function automatic bnms_pkg::t_out_item predict_pixel_op(bnms_pkg::t_in_item it);
        bnms_pkg::t_out_item res;
        logic      want;
        int        r;
        int        c;
        res = '0;
        r = it.row;
        c = it.col;
        if (it.action == bnms_pkg::ACT_FIND) begin
            for (int y = 0; y < N_ROWS && !res.found; y++)
                for (int x = 0; x < N_COLS && !res.found; x++)
                    if (img[y][x]) begin
                        res.found = 1'b1;
                        res.found_row = y[7:0];
                        res.found_col = x[7:0];
                    end
            return res;
        end
        if (it.action == bnms_pkg::ACT_SET || it.action == bnms_pkg::ACT_CLEAR) begin
            want = (it.action == bnms_pkg::ACT_SET);
            if (img[r][c] != want) begin
                img[r][c] = want;
                if (track_on) begin
                    flip_dir(r, c + 1, 0);
                    flip_dir(r - 1, c + 1, 1);
                    flip_dir(r - 1, c, 2);
                    flip_dir(r - 1, c - 1, 3);
                    flip_dir(r, c - 1, 4);
                    flip_dir(r + 1, c - 1, 5);
                    flip_dir(r + 1, c, 6);
                    flip_dir(r + 1, c + 1, 7);
                end
            end
        end
        res.pixel_value = img[r][c];
        res.neighbour_mask = nmask[r][c];
        return res;
    endfunction

    // result side: random stalls, compare at rising edge
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        bnms_pkg::t_out_item exp_res;
        if (i_rst_n && i_pop && !o_empty) begin
            n_popped++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_result);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result !== exp_res) begin
                    errors++;
                    $display("%0t: mismatch expected pix=%0b mask=%h fnd=%0b r=%0d c=%0d",
                             $time, exp_res.pixel_value, exp_res.neighbour_mask,
                             exp_res.found, exp_res.found_row, exp_res.found_col);
                    $display("%0t:          actual   pix=%0b mask=%h fnd=%0b r=%0d c=%0d",
                             $time, o_result.pixel_value, o_result.neighbour_mask,
                             o_result.found, o_result.found_row, o_result.found_col);
                end
            end
        end
    end

    // leaves i_push high; the next idle cycle or drain_results drops it
    task automatic send_item(bnms_pkg::t_in_item it, bit has_fixed,
                             bnms_pkg::t_out_item fixed_res);
        bnms_pkg::t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        pred = predict_pixel_op(it);
        if (has_fixed && pred !== fixed_res) begin
            errors++;
            $display("%0t: shadow model disagrees with table row %h", $time, it);
        end
        pending_results.push_back(pred);
        n_pushed++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_tracking(logic val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * bnms_pkg::REG_TRACKING);
        pwdata <= {31'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        track_on = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic bnms_pkg::t_in_item mk(bnms_pkg::t_action a, int r, int c);
        bnms_pkg::t_in_item it;
        it.action = a;
        it.row = r[7:0];
        it.col = c[7:0];
        return it;
    endfunction

    function automatic bnms_pkg::t_out_item px(logic p, logic [7:0] m);
        bnms_pkg::t_out_item o;
        o = '0;
        o.pixel_value = p;
        o.neighbour_mask = m;
        return o;
    endfunction

    typedef struct {
        bnms_pkg::t_in_item  item;
        bit                  fixed;
        bnms_pkg::t_out_item res;
    } t_row;

    // random item biased toward four small clusters so neighbours interact
    function automatic bnms_pkg::t_in_item rand_item();
        int r;
        int c;
        int a;
        a = $urandom_range(99);
        if ($urandom_range(3) == 0) begin
            r = $urandom_range(255);
            c = $urandom_range(255);
        end else begin
            r = ($urandom_range(1) ? 0 : 120) + $urandom_range(5);
            c = ($urandom_range(1) ? 60 : 250) + $urandom_range(5);
        end
        if (a < 40) return mk(bnms_pkg::ACT_SET, r, c);
        if (a < 70) return mk(bnms_pkg::ACT_CLEAR, r, c);
        if (a < 95) return mk(bnms_pkg::ACT_READ, r, c);
        return mk(bnms_pkg::ACT_FIND, r, c);
    endfunction

    initial begin
        t_row                dir_rows[$];
        bnms_pkg::t_out_item none;
        bnms_pkg::t_out_item fnd;
        none = '0;
        for (int y = 0; y < N_ROWS; y++)
            for (int x = 0; x < N_COLS; x++) begin
                img[y][x] = 1'b0;
                nmask[y][x] = '0;
            end
        track_on = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fnd = '0;
        fnd.found = 1'b1;
        fnd.found_row = 8'd255;
        fnd.found_col = 8'd255;
        dir_rows.push_back('{mk(bnms_pkg::ACT_FIND, 0, 0), 1, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 255, 255), 1, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 255, 255), 1, px(1, 8'h00)});
        dir_rows.push_back('{mk(bnms_pkg::ACT_FIND, 7, 9), 1, fnd});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 254, 254), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 255, 255), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 255, 255), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 0, 0), 1, px(1, 8'h00)});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 0, 1), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 1, 0), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 0, 0), 0, none});
        // word boundaries of both stores
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 10, 63), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 11, 64), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_SET, 9, 7), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 10, 8), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 10, 64), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_CLEAR, 11, 64), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_CLEAR, 11, 64), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_READ, 10, 63), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_FIND, 0, 0), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_CLEAR, 0, 0), 0, none});
        dir_rows.push_back('{mk(bnms_pkg::ACT_FIND, 255, 0), 0, none});

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);
        drain_results();

        // tracking off: masks freeze
        write_tracking(1'b0);
        send_item(mk(bnms_pkg::ACT_SET, 50, 50), 0, none);
        send_item(mk(bnms_pkg::ACT_SET, 50, 51), 0, none);
        send_item(mk(bnms_pkg::ACT_READ, 50, 51), 0, none);
        send_item(mk(bnms_pkg::ACT_READ, 10, 63), 0, none);
        drain_results();
        write_tracking(1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int k = 0; k < 120; k++)
                send_item(rand_item(), 0, none);
            drain_results();
            if (ph == 4) write_tracking(1'b0);
            if (ph == 6) write_tracking(1'b1);
        end
        recv_stall_pct = 0;
        drain_results();

        $display("covered %0d items, %0d results, all actions, tracking on and off",
                 n_pushed, n_popped);
        $display("edges of the image, word boundaries and idle/stall mixes included");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule
